### sv/assert_macros.svh
// Assertion helpers for the top-level RTL. Each macro expands to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at each rising edge of clk, skipped while rst is high.
`define ASSERT_ON(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Check prop at each rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`else

`define ASSERT_ON(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### sv/mtse_pkg.sv
package mtse_pkg;

  localparam int TAG_ENTRIES_DEF  = 4096;
  localparam int MAX_GRANULES_DEF = 64;
  localparam int GRANULE_BYTES    = 16;
  localparam int GRAN_SHIFT       = 4;

  localparam logic [7:0]  TAG_DEFAULT = 8'hFF;
  localparam logic [7:0]  TAG_FREED   = 8'hF0;
  localparam logic [31:0] LFSR_POLY   = 32'h04C1_1DB7;
  localparam logic [31:0] SEED_RESET  = 32'h0000_0001;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LFSR_SEED = 2'd2;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_GEN   = 2'd2,
    CMD_COPY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_VIOL = 2'd1,
    KIND_GEN  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    WR_CLEAR = 2'd0,
    WR_SET   = 2'd1,
    WR_COPY  = 2'd2
  } wr_sel_t;

  typedef enum logic [1:0] {
    OUT_PEND      = 2'd0,
    OUT_PEND_LAST = 2'd1,
    OUT_DONE      = 2'd2
  } out_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic     take;
    logic     rd_store;
    logic     rd_src;
    logic     wr_store;
    wr_sel_t  wr_sel;
    logic     buf_wr;
    logic     buf_rd;
    logic     g_inc;
    logic     g_zero;
    logic     pend_take;
    logic     lfsr_step;
    logic     mod_take;
    logic     out_load;
    out_sel_t out_sel;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    cmd_t cmd;
    logic loop_go;
    logic g_last;
    logic mismatch;
    logic pend_valid;
    logic out_free;
    logic clear_last;
  } ctrl_stat_t;

endpackage

### sv/mtse_datapath.sv
module mtse_datapath #(
  parameter int TAG_ENTRIES  = mtse_pkg::TAG_ENTRIES_DEF,
  parameter int MAX_GRANULES = mtse_pkg::MAX_GRANULES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mtse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mtse_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  mtse_pkg::cmd_t                       in_cmd,
  input  logic [63:0]                          in_address,
  input  logic [63:0]                          in_source_address,
  input  logic [10:0]                          in_length_bytes,
  input  logic [7:0]                           in_tag_value,
  input  logic                                 in_access_is_write,
  input  mtse_pkg::ctrl_cmd_t                  ctl,
  output mtse_pkg::ctrl_stat_t                 sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mtse_pkg::kind_t                      out_kind,
  output logic [63:0]                          out_result_address,
  output logic [7:0]                           out_tag_out,
  output logic                                 out_reason,
  output logic                                 out_access_write_out,
  output logic                                 out_last
);

  localparam int IDX_W   = $clog2(TAG_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_GRANULES + 1);
  localparam int BUF_AW  = (MAX_GRANULES > 1) ? $clog2(MAX_GRANULES) : 1;
  localparam int SUM_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int GADDR_W = 64 - mtse_pkg::GRAN_SHIFT;

  // configuration
  logic        check_en;
  logic        tag_en;
  logic [31:0] lfsr;

  // latched item
  mtse_pkg::cmd_t   cmd_q;
  logic [63:0]      addr_q;
  logic [63:0]      src_q;
  logic [CNT_W-1:0] cnt_q;
  logic [7:0]       tval_q;
  logic             wr_q;

  logic [CNT_W-1:0] g;
  logic             pend_valid;
  logic [63:0]      pend_addr;
  logic             pend_reason;
  logic [IDX_W-1:0] clr_idx;
  logic [8:0]       mod_sum;

  logic [7:0] tag_mem [TAG_ENTRIES];
  logic [7:0] store_q;
  logic [7:0] buf_mem [MAX_GRANULES];
  logic [7:0] buf_q;

  logic [11:0]        len_ceil;
  logic [7:0]         gran_raw;
  logic [CNT_W-1:0]   cnt_in;
  logic [SUM_W-1:0]   tgt_sum;
  logic [SUM_W-1:0]   src_sum;
  logic [IDX_W-1:0]   tgt_idx;
  logic [IDX_W-1:0]   src_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic [7:0]         wr_data;
  logic [7:0]         ptag;
  logic [GADDR_W-1:0] gran_addr;
  logic [63:0]        viol_addr;
  logic [31:0]        lfsr_next;
  logic [35:0]        chunk_src;
  logic [8:0]         chunk_sum;
  logic [6:0]         fold1;
  logic [3:0]         fold2;
  logic [3:0]         fold3;
  logic [2:0]         rem7;
  logic [3:0]         rem14;
  logic [7:0]         gen_tag;
  logic               set_ok;
  logic [63:0]        set_addr;
  logic               out_free;

  // granule count: round up, saturate
  assign len_ceil = {1'b0, in_length_bytes} + 12'(mtse_pkg::GRANULE_BYTES - 1);
  assign gran_raw = len_ceil[11:4];
  assign cnt_in   = (gran_raw > 8'(MAX_GRANULES)) ? CNT_W'(MAX_GRANULES) : CNT_W'(gran_raw);

  assign tgt_sum = SUM_W'(addr_q[mtse_pkg::GRAN_SHIFT +: IDX_W]) + SUM_W'(g);
  assign src_sum = SUM_W'(src_q[mtse_pkg::GRAN_SHIFT +: IDX_W]) + SUM_W'(g);
  assign tgt_idx = tgt_sum[IDX_W-1:0];
  assign src_idx = src_sum[IDX_W-1:0];
  assign rd_idx  = ctl.rd_src ? src_idx : tgt_idx;

  assign ptag      = addr_q[63:56] | mtse_pkg::TAG_FREED;
  assign gran_addr = addr_q[63:mtse_pkg::GRAN_SHIFT] + GADDR_W'(g);
  assign viol_addr = {ptag, gran_addr[51:0], 4'b0000};

  always_comb begin
    case (ctl.wr_sel)
      mtse_pkg::WR_CLEAR: begin
        wr_idx  = clr_idx;
        wr_data = mtse_pkg::TAG_DEFAULT;
      end
      mtse_pkg::WR_SET: begin
        wr_idx  = tgt_idx;
        wr_data = tval_q;
      end
      mtse_pkg::WR_COPY: begin
        wr_idx  = tgt_idx;
        wr_data = buf_q;
      end
      default: begin
        wr_idx  = tgt_idx;
        wr_data = mtse_pkg::TAG_DEFAULT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_store) begin
      tag_mem[wr_idx] <= wr_data;
    end
    if (ctl.rd_store) begin
      store_q <= tag_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.buf_wr) begin
      buf_mem[g[BUF_AW-1:0]] <= store_q;
    end
    if (ctl.buf_rd) begin
      buf_q <= buf_mem[g[BUF_AW-1:0]];
    end
  end

  assign lfsr_next = {1'b0, lfsr[31:1]} ^ (lfsr[0] ? mtse_pkg::LFSR_POLY : 32'h0);

  // v mod 14 = 2 * ((v >> 1) mod 7) + v[0]; 64 = 1 mod 7, so sum six-bit chunks
  assign chunk_src = {5'd0, lfsr[31:1]};
  always_comb begin
    chunk_sum = '0;
    for (int i = 0; i < 6; i++) begin
      chunk_sum = chunk_sum + 9'(chunk_src[6*i +: 6]);
    end
  end

  assign fold1   = 7'(mod_sum[5:0]) + 7'(mod_sum[8:6]);
  assign fold2   = 4'(fold1[2:0]) + 4'(fold1[5:3]) + 4'(fold1[6]);
  assign fold3   = 4'(fold2[2:0]) + 4'(fold2[3]);
  assign rem7    = (fold3 >= 4'd7) ? 3'(fold3 - 4'd7) : fold3[2:0];
  assign rem14   = {rem7, lfsr[0]};
  assign gen_tag = tag_en ? {4'hF, rem14 + 4'd1} : mtse_pkg::TAG_DEFAULT;

  assign set_ok   = tag_en && (cnt_q != '0);
  assign set_addr = set_ok ? {tval_q, addr_q[55:0]} : addr_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_en <= 1'b0;
      tag_en   <= 1'b0;
      lfsr     <= mtse_pkg::SEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mtse_pkg::REG_CHECK_EN:  check_en <= cfg_data[0];
        mtse_pkg::REG_TAG_EN:    tag_en   <= cfg_data[0];
        mtse_pkg::REG_LFSR_SEED: lfsr     <= cfg_data;
        default: ;
      endcase
    end else if (ctl.lfsr_step) begin
      lfsr <= lfsr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_q  <= in_cmd;
      addr_q <= in_address;
      src_q  <= in_source_address;
      cnt_q  <= cnt_in;
      tval_q <= in_tag_value;
      wr_q   <= in_access_is_write;
    end
    if (ctl.pend_take) begin
      pend_addr   <= viol_addr;
      pend_reason <= (store_q == mtse_pkg::TAG_FREED);
    end
    if (ctl.mod_take) begin
      mod_sum <= chunk_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g          <= '0;
      pend_valid <= 1'b0;
      clr_idx    <= '0;
    end else begin
      if (ctl.take || ctl.g_zero) begin
        g <= '0;
      end else if (ctl.g_inc) begin
        g <= g + CNT_W'(1);
      end
      if (ctl.take) begin
        pend_valid <= 1'b0;
      end else if (ctl.pend_take) begin
        pend_valid <= 1'b1;
      end
      if (ctl.wr_store && (ctl.wr_sel == mtse_pkg::WR_CLEAR)) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      case (ctl.out_sel)
        mtse_pkg::OUT_PEND, mtse_pkg::OUT_PEND_LAST: begin
          out_kind             <= mtse_pkg::KIND_VIOL;
          out_result_address   <= pend_addr;
          out_tag_out          <= ptag;
          out_reason           <= pend_reason;
          out_access_write_out <= wr_q;
          out_last             <= (ctl.out_sel == mtse_pkg::OUT_PEND_LAST);
        end
        default: begin
          out_reason           <= 1'b0;
          out_access_write_out <= 1'b0;
          out_last             <= 1'b1;
          case (cmd_q)
            mtse_pkg::CMD_SET: begin
              out_kind           <= mtse_pkg::KIND_DONE;
              out_result_address <= set_addr;
              out_tag_out        <= set_addr[63:56];
            end
            mtse_pkg::CMD_CHECK: begin
              out_kind           <= mtse_pkg::KIND_DONE;
              out_result_address <= addr_q;
              out_tag_out        <= ptag;
            end
            mtse_pkg::CMD_GEN: begin
              out_kind           <= mtse_pkg::KIND_GEN;
              out_result_address <= 64'd0;
              out_tag_out        <= gen_tag;
            end
            default: begin
              out_kind           <= mtse_pkg::KIND_DONE;
              out_result_address <= addr_q;
              out_tag_out        <= 8'd0;
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    sts.cmd = cmd_q;
    case (cmd_q)
      mtse_pkg::CMD_SET:   sts.loop_go = set_ok;
      mtse_pkg::CMD_CHECK: sts.loop_go = check_en && (ptag != mtse_pkg::TAG_DEFAULT)
                                         && (cnt_q != '0);
      mtse_pkg::CMD_GEN:   sts.loop_go = tag_en;
      default:             sts.loop_go = (cnt_q != '0);
    endcase
    sts.g_last     = ((g + CNT_W'(1)) == cnt_q);
    sts.mismatch   = (store_q != ptag);
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
    sts.clear_last = &clr_idx;
  end

endmodule

### sv/mtse_ctrl.sv
module mtse_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mtse_pkg::ctrl_stat_t sts,
  output mtse_pkg::ctrl_cmd_t  ctl
);

  typedef enum logic [13:0] {
    S_CLEAR = 14'h0001,
    S_IDLE  = 14'h0002,
    S_DISP  = 14'h0004,
    S_SET   = 14'h0008,
    S_RD    = 14'h0010,
    S_CMP   = 14'h0020,
    S_CEND  = 14'h0040,
    S_CRD   = 14'h0080,
    S_CBUF  = 14'h0100,
    S_BRD   = 14'h0200,
    S_BWR   = 14'h0400,
    S_GEN   = 14'h0800,
    S_GMOD  = 14'h1000,
    S_FIN   = 14'h2000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctl.wr_store = 1'b1;
        ctl.wr_sel   = mtse_pkg::WR_CLEAR;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.take   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts.loop_go) begin
          state_next = S_FIN;
        end else begin
          case (sts.cmd)
            mtse_pkg::CMD_SET:   state_next = S_SET;
            mtse_pkg::CMD_CHECK: state_next = S_RD;
            mtse_pkg::CMD_GEN:   state_next = S_GEN;
            mtse_pkg::CMD_COPY:  state_next = S_CRD;
            default:             state_next = S_FIN;
          endcase
        end
      end
      S_SET: begin
        ctl.wr_store = 1'b1;
        ctl.wr_sel   = mtse_pkg::WR_SET;
        if (sts.g_last) begin
          state_next = S_FIN;
        end else begin
          ctl.g_inc = 1'b1;
        end
      end
      S_RD: begin
        ctl.rd_store = 1'b1;
        state_next   = S_CMP;
      end
      S_CMP: begin
        // hold while a new mismatch must push out the pending one and the
        // output register is still full
        if (!(sts.mismatch && sts.pend_valid && !sts.out_free)) begin
          if (sts.mismatch && sts.pend_valid) begin
            ctl.out_load = 1'b1;
            ctl.out_sel  = mtse_pkg::OUT_PEND;
          end
          ctl.pend_take = sts.mismatch;
          if (sts.g_last) begin
            state_next = S_CEND;
          end else begin
            ctl.g_inc  = 1'b1;
            state_next = S_RD;
          end
        end
      end
      S_CEND: begin
        if (!sts.pend_valid) begin
          state_next = S_FIN;
        end else if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_sel  = mtse_pkg::OUT_PEND_LAST;
          state_next   = S_IDLE;
        end
      end
      S_CRD: begin
        ctl.rd_store = 1'b1;
        ctl.rd_src   = 1'b1;
        state_next   = S_CBUF;
      end
      S_CBUF: begin
        ctl.buf_wr = 1'b1;
        if (sts.g_last) begin
          ctl.g_zero = 1'b1;
          state_next = S_BRD;
        end else begin
          ctl.g_inc  = 1'b1;
          state_next = S_CRD;
        end
      end
      S_BRD: begin
        ctl.buf_rd = 1'b1;
        state_next = S_BWR;
      end
      S_BWR: begin
        ctl.wr_store = 1'b1;
        ctl.wr_sel   = mtse_pkg::WR_COPY;
        if (sts.g_last) begin
          state_next = S_FIN;
        end else begin
          ctl.g_inc  = 1'b1;
          state_next = S_BRD;
        end
      end
      S_GEN: begin
        ctl.lfsr_step = 1'b1;
        state_next    = S_GMOD;
      end
      S_GMOD: begin
        ctl.mod_take = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_sel  = mtse_pkg::OUT_DONE;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/memory_tag_store_engine.sv
// Channel   Dir  Words                      Handshake
// s_axis    in   one command per word       tvalid/tready
// m_axis    out  one or more results/cmd    tvalid/tready, tlast on the final one
// cfg       in   register write             cfg_we, no back-pressure
//
// Per command, N = granule count (0..MAX_GRANULES): set and check walk N granules, copy reads
// N source granules then writes N targets, generate steps the LFSR; a skipped loop walks none.
// Reset: a clearing pass writes 0xFF into every tag entry with s_axis_tready low;
// configuration writes are taken during it.
// Stalls: with the output register full, a check holds at a mismatch that would evict a
// pending one, the final word waits; a new command is taken while the last result sits there.
`include "assert_macros.svh"

module memory_tag_store_engine #(
  // TAG_ENTRIES must be a power of two: the store index is the low address bits.
  parameter int TAG_ENTRIES  = mtse_pkg::TAG_ENTRIES_DEF,
  parameter int MAX_GRANULES = mtse_pkg::MAX_GRANULES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration writes
  input  logic                                cfg_we,
  input  logic [mtse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mtse_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Command stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // address[63:0], source_address[127:64], length_bytes[138:128],
  // tag_value[146:139], access_is_write[147], zero[151:148]
  input  logic [mtse_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                          s_axis_tuser,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_address[63:0], tag_out[71:64], reason[72], access_write_out[73],
  // zero[79:74]
  output logic [mtse_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // kind[1:0]
  output logic [1:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  mtse_pkg::ctrl_cmd_t  ctl;
  mtse_pkg::ctrl_stat_t sts;
  mtse_pkg::kind_t      out_kind;
  logic [63:0]          out_addr;
  logic [7:0]           out_tag;
  logic                 out_reason;
  logic                 out_wr;

  // Sequence each command: dispatch, walk the granules, post the result.
  mtse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Tag store, copy buffer, LFSR, configuration and output register.
  mtse_datapath #(
    .TAG_ENTRIES  (TAG_ENTRIES),
    .MAX_GRANULES (MAX_GRANULES)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_cmd               (mtse_pkg::cmd_t'(s_axis_tuser)),
    .in_address           (s_axis_tdata[63:0]),
    .in_source_address    (s_axis_tdata[127:64]),
    .in_length_bytes      (s_axis_tdata[138:128]),
    .in_tag_value         (s_axis_tdata[146:139]),
    .in_access_is_write   (s_axis_tdata[147]),
    .ctl                  (ctl),
    .sts                  (sts),
    .out_valid            (m_axis_tvalid),
    .out_ready            (m_axis_tready),
    .out_kind             (out_kind),
    .out_result_address   (out_addr),
    .out_tag_out          (out_tag),
    .out_reason           (out_reason),
    .out_access_write_out (out_wr),
    .out_last             (m_axis_tlast)
  );

  // Pack the result word, first field in the low bits.
  assign m_axis_tdata = {6'd0, out_wr, out_reason, out_tag, out_addr};
  assign m_axis_tuser = out_kind;

  // Never overwrite a result word that has not been taken.
  `ASSERT_ON(a_load_needs_room, clk, rst, ctl.out_load |-> sts.out_free)
  // Store writes (clear, set, copy) only while no command is being taken.
  `ASSERT_ON(a_store_write_busy, clk, rst, ctl.wr_store |-> !s_axis_tready)
  // The clearing pass follows reset, so no command is taken right after it.
  `ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> !s_axis_tready)
  // A generated-tag word carries a zero address.
  `ASSERT_ON(a_gen_addr_zero, clk, rst, (m_axis_tuser == mtse_pkg::KIND_GEN) |-> !(|out_addr))

endmodule

### sim/tb.sv
module tb;

  localparam int SLOT_W = $clog2(mtse_pkg::TAG_ENTRIES_DEF);
  // Settling time; it outlasts the longest command, a copy of 64 granules.
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 50;
  // Index with no register behind it; writes there must be dropped.
  localparam logic [mtse_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    mtse_pkg::cmd_t op;
    logic [63:0]    addr;
    logic [63:0]    src;
    logic [10:0]    len;
    logic [7:0]     tag;
    logic           wr;
  } tag_cmd_t;

  typedef struct {
    mtse_pkg::kind_t kind;
    logic [63:0]     addr;
    logic [7:0]      tag;
    logic            reason;
    logic            wr;
    logic            last;
  } tag_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [mtse_pkg::CFG_IDX_W-1:0] cfg_index = mtse_pkg::REG_CHECK_EN;
  logic [mtse_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mtse_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = mtse_pkg::CMD_SET;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mtse_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  // Mirror of the engine: tag store, generator state and register copies.
  logic [7:0]  tag_mirror [mtse_pkg::TAG_ENTRIES_DEF];
  logic [31:0] gen_state = mtse_pkg::SEED_RESET;
  logic        check_on = 1'b0;
  logic        tagging_on = 1'b0;

  tag_cmd_t    queued_commands[$];
  tag_result_t awaited_results[$];
  tag_cmd_t    on_bus;

  int sent_count = 0;
  int seen_count = 0;
  int fail_count = 0;
  int cycle_count = 0;

  memory_tag_store_engine u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store entry of granule g counted from address a; wraps around the store.
  function automatic logic [SLOT_W-1:0] granule_slot(logic [63:0] a, int unsigned g);
    logic [63:0] idx;
    idx = (a >> mtse_pkg::GRAN_SHIFT) + 64'(g);
    return idx[SLOT_W-1:0];
  endfunction

  function automatic tag_result_t tag_result(mtse_pkg::kind_t k, logic [63:0] a,
                                             logic [7:0] t, logic why, logic wr,
                                             logic last);
    tag_result_t r;
    r.kind = k;
    r.addr = a;
    r.tag = t;
    r.reason = why;
    r.wr = wr;
    r.last = last;
    return r;
  endfunction

  // Work out the words one command yields and update the mirrored state.
  task automatic apply_tag_command(input tag_cmd_t c);
    int unsigned cnt;
    logic [7:0]  ptag;
    logic [7:0]  stored;
    logic [63:0] base;
    logic [63:0] res;
    logic [31:0] v;
    logic [7:0]  moved [mtse_pkg::MAX_GRANULES_DEF];
    tag_result_t held;
    bit          have_held;
    cnt = (int'(c.len) + mtse_pkg::GRANULE_BYTES - 1) / mtse_pkg::GRANULE_BYTES;
    if (cnt > mtse_pkg::MAX_GRANULES_DEF) cnt = mtse_pkg::MAX_GRANULES_DEF;
    have_held = 0;
    case (c.op)
      mtse_pkg::CMD_SET: begin
        res = c.addr;
        if (tagging_on && cnt > 0) begin
          for (int unsigned g = 0; g < cnt; g++) tag_mirror[granule_slot(c.addr, g)] = c.tag;
          res = {c.tag, c.addr[55:0]};
        end
        awaited_results.push_back(tag_result(mtse_pkg::KIND_DONE, res, res[63:56],
                                             1'b0, 1'b0, 1'b1));
      end
      mtse_pkg::CMD_CHECK: begin
        ptag = c.addr[63:56] | mtse_pkg::TAG_FREED;
        if (check_on && ptag != mtse_pkg::TAG_DEFAULT) begin
          base = c.addr & ~64'(mtse_pkg::GRANULE_BYTES - 1);
          for (int unsigned g = 0; g < cnt; g++) begin
            stored = tag_mirror[granule_slot(c.addr, g)];
            if (stored != ptag) begin
              // Hold one violation back so the final one can carry tlast.
              if (have_held) awaited_results.push_back(held);
              res = base + 64'(g) * mtse_pkg::GRANULE_BYTES;
              held = tag_result(mtse_pkg::KIND_VIOL, {ptag, res[55:0]}, ptag,
                                stored == mtse_pkg::TAG_FREED, c.wr, 1'b0);
              have_held = 1;
            end
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          awaited_results.push_back(held);
        end else begin
          awaited_results.push_back(tag_result(mtse_pkg::KIND_DONE, c.addr, ptag,
                                               1'b0, 1'b0, 1'b1));
        end
      end
      mtse_pkg::CMD_GEN: begin
        stored = mtse_pkg::TAG_DEFAULT;
        if (tagging_on) begin
          v = {1'b0, gen_state[31:1]} ^ (gen_state[0] ? mtse_pkg::LFSR_POLY : 32'h0);
          gen_state = v;
          stored = mtse_pkg::TAG_FREED | 8'((v % 14) + 1);
        end
        awaited_results.push_back(tag_result(mtse_pkg::KIND_GEN, 64'h0, stored,
                                             1'b0, 1'b0, 1'b1));
      end
      default: begin
        // Read the whole source first so overlapping ranges move cleanly.
        for (int unsigned g = 0; g < cnt; g++) moved[g] = tag_mirror[granule_slot(c.src, g)];
        for (int unsigned g = 0; g < cnt; g++) tag_mirror[granule_slot(c.addr, g)] = moved[g];
        awaited_results.push_back(tag_result(mtse_pkg::KIND_DONE, c.addr, 8'h00,
                                             1'b0, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: mismatch in %s of result word %0d: got %h, want %h",
             what, seen_count, got, want);
    fail_count++;
  endtask

  // Command driver: take the next queued word once the current one is gone,
  // idle about one cycle in five outside the steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        apply_tag_command(on_bus);
        sent_count++;
      end
      if (queued_commands.size() != 0 &&
          ((sent_count >= 120 && sent_count < 180) || $urandom_range(99) >= 20)) begin
        on_bus = queued_commands.pop_front();
        s_axis_tdata <= {4'b0, on_bus.wr, on_bus.tag, on_bus.len, on_bus.src, on_bus.addr};
        s_axis_tuser <= on_bus.op;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each accepted word against the oldest expectation,
  // stall about one cycle in five outside the steady stretch.
  always @(posedge clk) begin
    tag_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata[63:0], 64'h0);
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tuser !== want.kind) report_mismatch("kind", m_axis_tuser, want.kind);
          if (m_axis_tdata[63:0] !== want.addr)
            report_mismatch("result_address", m_axis_tdata[63:0], want.addr);
          if (m_axis_tdata[71:64] !== want.tag)
            report_mismatch("tag_out", m_axis_tdata[71:64], want.tag);
          if (m_axis_tdata[72] !== want.reason)
            report_mismatch("reason", m_axis_tdata[72], want.reason);
          if (m_axis_tdata[73] !== want.wr)
            report_mismatch("access_write_out", m_axis_tdata[73], want.wr);
          if (m_axis_tlast !== want.last) report_mismatch("last", m_axis_tlast, want.last);
        end
        seen_count++;
      end
      m_axis_tready <= (seen_count >= 200 && seen_count < 320) || $urandom_range(99) >= 20;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_command(input mtse_pkg::cmd_t op, input logic [63:0] addr,
                               input logic [63:0] src, input int len,
                               input logic [7:0] tag, input logic wr);
    tag_cmd_t c;
    c.op = op;
    c.addr = addr;
    c.src = src;
    c.len = 11'(len);
    c.tag = tag;
    c.wr = wr;
    queued_commands.push_back(c);
  endtask

  // Random pointer whose granule index lands on the given store entry.
  function automatic logic [63:0] slot_addr(int slot, logic [7:0] top);
    logic [63:0] a;
    a = {$urandom, $urandom};
    a[63:56] = top;
    a[SLOT_W+3:4] = SLOT_W'(slot);
    return a;
  endfunction

  // Mostly short ranges, now and then longer ones up to the saturation point.
  function automatic int pick_length();
    if ($urandom_range(9) == 0) return $urandom_range(129, 1024);
    return $urandom_range(0, 128);
  endfunction

  task automatic write_reg(input logic [mtse_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      mtse_pkg::REG_CHECK_EN:  check_on = val[0];
      mtse_pkg::REG_TAG_EN:    tagging_on = val[0];
      mtse_pkg::REG_LFSR_SEED: gen_state = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_engine(input logic chk, input logic tg, input logic [31:0] seed);
    write_reg(mtse_pkg::REG_CHECK_EN, {31'b0, chk});
    write_reg(mtse_pkg::REG_TAG_EN, {31'b0, tg});
    write_reg(mtse_pkg::REG_LFSR_SEED, seed);
    @(negedge clk);
  endtask

  // Wait for every queued word to go in and every expected word to come out,
  // then let the engine settle before the next phase.
  task automatic wait_idle();
    do @(negedge clk);
    while (queued_commands.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int slot;
    int src_slot;
    int span;
    int off;
    int n_items;
    logic [7:0] t;
    logic [7:0] top;

    foreach (tag_mirror[i]) tag_mirror[i] = mtse_pkg::TAG_DEFAULT;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: tagging and checking both off.
    queue_command(mtse_pkg::CMD_SET, slot_addr(16, 8'h12), 64'h0, 64, 8'hF3, 1'b0);
    queue_command(mtse_pkg::CMD_CHECK, slot_addr(16, 8'h03), 64'h0, 64, 8'h00, 1'b1);
    queue_command(mtse_pkg::CMD_GEN, 64'h0, 64'h0, 0, 8'h00, 1'b0);
    queue_command(mtse_pkg::CMD_COPY, slot_addr(16, 8'h00), slot_addr(256, 8'h77), 32,
                  8'h00, 1'b0);
    wait_idle();

    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    program_engine(1'b1, 1'b1, 32'hFFFF_FFFF);
    // Tag a range, hit it, overrun it, wildcard and empty checks.
    queue_command(mtse_pkg::CMD_SET, slot_addr(16, 8'h00), 64'h0, 64, 8'hF3, 1'b0);
    queue_command(mtse_pkg::CMD_CHECK, slot_addr(16, 8'h03), 64'h0, 64, 8'h00, 1'b1);
    queue_command(mtse_pkg::CMD_CHECK, {8'h03, 40'h0, 12'h010, 4'h9}, 64'h0, 96, 8'h00,
                  1'b1);
    queue_command(mtse_pkg::CMD_CHECK, slot_addr(16, 8'h0F), 64'h0, 1024, 8'h00, 1'b1);
    queue_command(mtse_pkg::CMD_CHECK, slot_addr(16, 8'h03), 64'h0, 0, 8'h00, 1'b1);
    // Free the range, then touch it again: use after free.
    queue_command(mtse_pkg::CMD_SET, slot_addr(16, 8'h00), 64'h0, 64, mtse_pkg::TAG_FREED,
                  1'b0);
    queue_command(mtse_pkg::CMD_CHECK, slot_addr(16, 8'hA3), 64'h0, 64, 8'h00, 1'b0);
    queue_command(mtse_pkg::CMD_SET, slot_addr(20, 8'h66), 64'h0, 0, 8'h5A, 1'b0);
    // Full-size range at the top of memory: store index and address both wrap.
    queue_command(mtse_pkg::CMD_SET, 64'hFFFF_FFFF_FFFF_FFE0, 64'h0, 1024, 8'h00, 1'b0);
    queue_command(mtse_pkg::CMD_CHECK, 64'h05FF_FFFF_FFFF_FFE8, 64'h0, 64, 8'h00, 1'b1);
    // Overlapping copy, one granule up.
    queue_command(mtse_pkg::CMD_SET, slot_addr(64, 8'h00), 64'h0, 32, 8'hF7, 1'b0);
    queue_command(mtse_pkg::CMD_SET, slot_addr(66, 8'h00), 64'h0, 32, 8'hF9, 1'b0);
    queue_command(mtse_pkg::CMD_COPY, slot_addr(65, 8'hC4), slot_addr(64, 8'h3B), 64,
                  8'h00, 1'b0);
    queue_command(mtse_pkg::CMD_CHECK, slot_addr(64, 8'h07), 64'h0, 80, 8'h00, 1'b0);
    queue_command(mtse_pkg::CMD_COPY, slot_addr(90, 8'h00), slot_addr(64, 8'h00), 0,
                  8'h00, 1'b0);
    queue_command(mtse_pkg::CMD_GEN, 64'h0, 64'h0, 0, 8'h00, 1'b0);
    queue_command(mtse_pkg::CMD_GEN, 64'h0, 64'h0, 0, 8'h00, 1'b0);
    // Untouched region: every granule of a saturated range mismatches.
    queue_command(mtse_pkg::CMD_CHECK, slot_addr(512, 8'h01), 64'h0, 1024, 8'h00, 1'b1);
    queue_command(mtse_pkg::CMD_SET, slot_addr(768, 8'h00), 64'h0, 1, mtse_pkg::TAG_DEFAULT,
                  1'b0);
    wait_idle();

    // A zero seed pins the generator.
    write_reg(mtse_pkg::REG_LFSR_SEED, 32'h0);
    @(negedge clk);
    queue_command(mtse_pkg::CMD_GEN, 64'h0, 64'h0, 0, 8'h00, 1'b0);
    queue_command(mtse_pkg::CMD_GEN, 64'h0, 64'h0, 0, 8'h00, 1'b0);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      program_engine(p != 2, p != 3,
                     (p == 1) ? 32'hFFFF_FFFF : (p == 3) ? 32'h0 : $urandom);
      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        off = $urandom_range(99);
        if (off < 70) begin
          // Allocation lifetime: tag, access, maybe free and access again.
          slot = ($urandom_range(9) == 0) ? $urandom_range(4000, 4095) : $urandom_range(0, 383);
          span = ($urandom_range(9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
          t = mtse_pkg::TAG_FREED | 8'($urandom_range(1, 14));
          if ($urandom_range(2) == 0) begin
            queue_command(mtse_pkg::CMD_GEN, 64'h0, 64'h0, 0, 8'($urandom), 1'($urandom));
            n_items++;
          end
          queue_command(mtse_pkg::CMD_SET, slot_addr(slot, 8'($urandom)), 64'($urandom),
                        span * 16 - $urandom_range(0, 15), t, 1'($urandom));
          n_items++;
          repeat ($urandom_range(1, 3)) begin
            top = ($urandom_range(5) == 0) ? 8'($urandom) : {4'($urandom), t[3:0]};
            off = $urandom_range(0, 2);
            queue_command(mtse_pkg::CMD_CHECK,
                          slot_addr((slot + off) % mtse_pkg::TAG_ENTRIES_DEF, top), 64'h0,
                          $urandom_range(1, span * 16 + 32), 8'($urandom), 1'($urandom));
            n_items++;
          end
          if ($urandom_range(1) == 0) begin
            queue_command(mtse_pkg::CMD_SET, slot_addr(slot, 8'($urandom)), 64'h0, span * 16,
                          mtse_pkg::TAG_FREED, 1'b0);
            queue_command(mtse_pkg::CMD_CHECK, slot_addr(slot, {4'($urandom), t[3:0]}), 64'h0,
                          span * 16, 8'h00, 1'($urandom));
            n_items += 2;
          end
        end else if (off < 85) begin
          // Move tags near a tagged area, then probe the target.
          slot = $urandom_range(0, 383);
          src_slot = (slot + $urandom_range(0, 8) + 4092) % mtse_pkg::TAG_ENTRIES_DEF;
          queue_command(mtse_pkg::CMD_COPY, slot_addr(slot, 8'($urandom)),
                        slot_addr(src_slot, 8'($urandom)),
                        pick_length(), 8'($urandom), 1'($urandom));
          queue_command(mtse_pkg::CMD_CHECK, slot_addr(slot, 8'($urandom)), 64'h0,
                        pick_length(), 8'($urandom), 1'($urandom));
          n_items += 2;
        end else begin
          // Noise: any command with any fields.
          queue_command(mtse_pkg::cmd_t'($urandom_range(0, 3)), {$urandom, $urandom},
                        {$urandom, $urandom}, $urandom_range(0, 1024), 8'($urandom),
                        1'($urandom));
          n_items++;
        end
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/mtse_pkg.sv
sv/mtse_datapath.sv
sv/mtse_ctrl.sv
sv/memory_tag_store_engine.sv
sim/tb.sv
